@@ src/flight_landing_detector_assert.svh @@
// Assertion macros for the flight landing detector checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef FLIGHT_LANDING_DETECTOR_ASSERT_SVH
`define FLIGHT_LANDING_DETECTOR_ASSERT_SVH
// Same-cycle implication, disabled while reset is asserted.
`define FLD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled while reset is asserted.
`define FLD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

@@ src/fld_pkg.sv @@
// Shared types and constants of the flight landing detector.
// No dependencies; compiled before every other file of the block.
`timescale 1ns / 1ps
`default_nettype none
package fld_pkg;

    localparam int ALT_W       = 24;
    localparam int IDX_W       = 12;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPW         = $clog2(QUEUE_DEPTH);
    localparam int QCW         = $clog2(QUEUE_DEPTH + 1);

    localparam logic REQ_TRIGGER = 1'b0;
    localparam logic REQ_SAMPLE  = 1'b1;

    localparam logic [1:0] MODE_PRE  = 2'd0;
    localparam logic [1:0] MODE_FLY  = 2'd1;
    localparam logic [1:0] MODE_LAND = 2'd2;
    localparam logic [1:0] MODE_FAIL = 2'd3;

    localparam logic [1:0] REASON_NONE = 2'd0;
    localparam logic [1:0] REASON_DEV  = 2'd1;
    localparam logic [1:0] REASON_FULL = 2'd2;

    typedef enum logic [3:0] {
        ST_PRE  = 4'b0001,
        ST_FLY  = 4'b0010,
        ST_LAND = 4'b0100,
        ST_FAIL = 4'b1000
    } t_mode;

    // One queued item after classification.
    typedef struct packed {
        logic                    is_sample;
        logic signed [ALT_W-1:0] altitude;
    } t_item;

    // What the statistics pipeline hands to the sequencer for one item.
    typedef struct packed {
        logic is_sample;
        logic near;
    } t_verdict;

endpackage
`default_nettype wire

@@ src/fld_if.sv @@
// Valid/ready channel interfaces of the flight landing detector.
// Depends on fld_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none
interface fld_in_if;
    logic                            valid;
    logic                            ready;
    logic                            req_type;
    logic signed [fld_pkg::ALT_W-1:0] altitude;

    modport source (output valid, output req_type, output altitude, input ready);
    modport sink   (input valid, input req_type, input altitude, output ready);
endinterface

interface fld_out_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                mode;
    logic                      landed_now;
    logic [1:0]                land_reason;
    logic [fld_pkg::IDX_W-1:0] sample_index;

    modport source (output valid, output mode, output landed_now, output land_reason,
                    output sample_index, input ready);
    modport sink   (input valid, input mode, input landed_now, input land_reason,
                    input sample_index, output ready);
endinterface
`default_nettype wire

@@ src/fld_front.sv @@
// Front end: accepts input items, classifies them and queues them for the back end.
// Depends on fld_pkg and fld_in_if.
`timescale 1ns / 1ps
`default_nettype none
module fld_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    fld_in_if.sink         i_in,
    input  logic           i_pop,
    output logic           o_valid,
    output fld_pkg::t_item o_item
);
    import fld_pkg::*;

    t_item            r_mem [QUEUE_DEPTH];
    logic [QPW-1:0]   r_wr;
    logic [QPW-1:0]   r_rd;
    logic [QCW-1:0]   r_cnt;
    logic             push;
    logic             pop;
    t_item            in_item;

    assign i_in.ready = (r_cnt != QCW'(QUEUE_DEPTH));
    assign push       = i_in.valid && i_in.ready;
    assign o_valid    = (r_cnt != '0);
    assign pop        = i_pop && o_valid;
    assign o_item     = r_mem[r_rd];

    always_comb begin
        in_item.is_sample = (i_in.req_type == REQ_SAMPLE);
        in_item.altitude  = i_in.altitude;
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + QPW'(1);
            end
            if (pop) begin
                r_rd <= r_rd + QPW'(1);
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + QCW'(1);
            end else if (pop && !push) begin
                r_cnt <= r_cnt - QCW'(1);
            end
        end
    end

endmodule
`default_nettype wire

@@ src/fld_stats.sv @@
// Back end statistics pipeline: sliding window sums and the one-deviation test.
// Depends on fld_pkg. Advances in lock step with the sequencer.
`timescale 1ns / 1ps
`default_nettype none
module fld_stats #(
    parameter int WINDOW_LEN = 5
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  fld_pkg::t_item    i_item,
    output logic              o_valid,
    output fld_pkg::t_verdict o_verdict
);
    import fld_pkg::*;

    localparam int SW = ALT_W + $clog2(WINDOW_LEN);
    localparam int DW = SW + 1;
    localparam int QW = 2 * ALT_W - 1 + $clog2(WINDOW_LEN);
    localparam int PW = 2 * DW + 1;
    localparam int FW = $clog2(WINDOW_LEN + 1);
    localparam logic signed [DW-1:0] N_S = DW'(WINDOW_LEN);
    localparam logic [PW-1:0]        N_U = PW'(WINDOW_LEN);

    typedef struct packed {
        logic                    is_sample;
        logic signed [ALT_W-1:0] x;
        logic signed [SW-1:0]    s;
        logic                    full;
        logic [QW-1:0]           xsq;
    } t_p2;

    typedef struct packed {
        logic                 is_sample;
        logic signed [SW-1:0] s;
        logic [QW-1:0]        q;
        logic signed [DW-1:0] d;
    } t_p3;

    typedef struct packed {
        logic            is_sample;
        logic [2*DW-1:0] dsq;
        logic [2*SW-1:0] ssq;
        logic [PW-1:0]   nq;
    } t_p4;

    // The window and sums follow every sample since the last trigger. While the
    // flight is on they equal the stored window; afterwards no test reads them.
    logic signed [ALT_W-1:0] r_win   [WINDOW_LEN];
    logic [QW-1:0]           r_sqwin [WINDOW_LEN];
    logic [FW-1:0]           r_fill;
    logic signed [SW-1:0]    r_sum;
    logic [QW-1:0]           r_q;

    logic     r_v2, r_v3, r_v4, r_v5;
    t_p2      r_p2;
    t_p3      r_p3;
    t_p4      r_p4;
    t_verdict r_p5;

    logic                      full1;
    logic signed [SW-1:0]      x_ext;
    logic signed [SW-1:0]      old_ext;
    logic signed [SW-1:0]      n_sum;
    logic signed [2*ALT_W-1:0] prod;
    logic [QW-1:0]             old_sq;
    logic [QW-1:0]             n_q;
    logic signed [DW-1:0]      x2_ext;
    logic signed [DW-1:0]      s2_ext;
    logic signed [DW-1:0]      nx;
    logic signed [2*DW-1:0]    dsq;
    logic signed [2*SW-1:0]    ssq;
    logic [PW-1:0]             lhs;

    // Stage 1: running sum of the window, square of the new sample.
    always_comb begin
        full1   = (r_fill == FW'(WINDOW_LEN));
        x_ext   = {{(SW-ALT_W){i_item.altitude[ALT_W-1]}}, i_item.altitude};
        old_ext = full1 ? {{(SW-ALT_W){r_win[WINDOW_LEN-1][ALT_W-1]}}, r_win[WINDOW_LEN-1]}
                        : '0;
        n_sum   = r_sum + x_ext - old_ext;
        prod    = i_item.altitude * i_item.altitude;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_sum  <= '0;
        end else if (i_en && i_valid) begin
            if (i_item.is_sample) begin
                r_sum <= n_sum;
                if (!full1) begin
                    r_fill <= r_fill + FW'(1);
                end
            end else begin
                r_sum  <= '0;
                r_fill <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && i_valid && i_item.is_sample) begin
            r_win[0] <= i_item.altitude;
            for (int i = 1; i < WINDOW_LEN; i++) begin
                r_win[i] <= r_win[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p2.is_sample <= i_item.is_sample;
            r_p2.x         <= i_item.altitude;
            r_p2.s         <= r_sum;
            r_p2.full      <= full1;
            r_p2.xsq       <= {{(QW-(2*ALT_W-1)){1'b0}}, prod[2*ALT_W-2:0]};
        end
    end

    // Stage 2: running sum of squares, distance of the sample from the mean.
    always_comb begin
        old_sq = r_p2.full ? r_sqwin[WINDOW_LEN-1] : '0;
        n_q    = r_q + r_p2.xsq - old_sq;
        x2_ext = {{(DW-ALT_W){r_p2.x[ALT_W-1]}}, r_p2.x};
        s2_ext = {r_p2.s[SW-1], r_p2.s};
        nx     = N_S * x2_ext;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= '0;
        end else if (i_en && r_v2) begin
            r_q <= r_p2.is_sample ? n_q : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && r_v2 && r_p2.is_sample) begin
            r_sqwin[0] <= r_p2.xsq;
            for (int i = 1; i < WINDOW_LEN; i++) begin
                r_sqwin[i] <= r_sqwin[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p3.is_sample <= r_p2.is_sample;
            r_p3.s         <= r_p2.s;
            r_p3.q         <= r_q;
            r_p3.d         <= nx - s2_ext;
        end
    end

    // Stage 3: the three products of (n*x - S)^2 <= n*Q - S^2.
    always_comb begin
        dsq = r_p3.d * r_p3.d;
        ssq = r_p3.s * r_p3.s;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p4.is_sample <= r_p3.is_sample;
            r_p4.dsq       <= dsq;
            r_p4.ssq       <= ssq;
            r_p4.nq        <= PW'(r_p3.q) * N_U;
        end
    end

    // Stage 4: compare. Both squares are non-negative, so zero extension is exact.
    assign lhs = PW'(r_p4.dsq) + PW'(r_p4.ssq);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p5.is_sample <= r_p4.is_sample;
            r_p5.near      <= (lhs <= r_p4.nq);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else if (i_en) begin
            r_v2 <= i_valid;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    assign o_valid   = r_v5;
    assign o_verdict = r_p5;

endmodule
`default_nettype wire

@@ src/fld_seq.sv @@
// Back end sequencer: flight mode, sample count and the registered result item.
// Depends on fld_pkg and fld_out_if; drives the advance of the statistics pipeline.
`timescale 1ns / 1ps
`default_nettype none
module fld_seq #(
    parameter int LOG_DEPTH  = 2048,
    parameter int WINDOW_LEN = 5
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  fld_pkg::t_verdict i_verdict,
    input  logic              i_cfg_we,
    input  logic              i_cfg_wdata,
    output logic              o_en,
    fld_out_if.source         o_out
);
    import fld_pkg::*;

    localparam int CNTW = $clog2(LOG_DEPTH + 1);
    localparam int CMPW = CNTW + 6;

    t_mode            r_mode;
    t_mode            n_mode;
    logic [CNTW-1:0]  r_count;
    logic [CNTW-1:0]  n_count;
    logic [CNTW-1:0]  cnt_inc;
    logic             landed;
    logic [1:0]       reason;
    logic             check;
    logic             r_out_valid;
    logic [1:0]       r_out_mode;
    logic             r_out_landed;
    logic [1:0]       r_out_reason;
    logic [IDX_W-1:0] r_out_index;

    function automatic logic [1:0] mode_code(input t_mode m);
        logic [1:0] c;
        unique case (m)
            ST_PRE:  c = MODE_PRE;
            ST_FLY:  c = MODE_FLY;
            ST_LAND: c = MODE_LAND;
            ST_FAIL: c = MODE_FAIL;
            default: c = MODE_FAIL;
        endcase
        return c;
    endfunction

    assign o_en = !r_out_valid || o_out.ready;

    always_comb begin
        n_mode  = r_mode;
        n_count = r_count;
        landed  = 1'b0;
        reason  = REASON_NONE;
        cnt_inc = (r_count < CNTW'(LOG_DEPTH)) ? r_count + CNTW'(1) : r_count;
        check   = (CMPW'(r_count) >= CMPW'(WINDOW_LEN + 1));
        if (!i_verdict.is_sample) begin
            if (r_mode != ST_FAIL) begin
                n_mode  = ST_FLY;
                n_count = '0;
            end
        end else if (r_mode == ST_FLY) begin
            n_count = cnt_inc;
            // A passing test takes precedence over a full store.
            if (check && i_verdict.near) begin
                n_mode = ST_LAND;
                landed = 1'b1;
                reason = REASON_DEV;
            end else if (cnt_inc == CNTW'(LOG_DEPTH)) begin
                n_mode = ST_LAND;
                landed = 1'b1;
                reason = REASON_FULL;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= ST_PRE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_wdata) begin
                    r_mode <= ST_FAIL;
                end else if (r_mode == ST_FAIL) begin
                    r_mode  <= ST_PRE;
                    r_count <= '0;
                end
            end else if (o_en && i_valid) begin
                r_mode  <= n_mode;
                r_count <= n_count;
            end
            if (o_en) begin
                r_out_valid <= i_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en && i_valid) begin
            r_out_mode   <= mode_code(n_mode);
            r_out_landed <= landed;
            r_out_reason <= reason;
            r_out_index  <= IDX_W'(n_count);
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.mode         = r_out_mode;
    assign o_out.landed_now   = r_out_landed;
    assign o_out.land_reason  = r_out_reason;
    assign o_out.sample_index = r_out_index;

endmodule
`default_nettype wire

@@ src/flight_landing_detector.sv @@
// Flight landing detector top level: queue front end, statistics pipeline, sequencer.
// Depends on fld_pkg, fld_if, fld_front, fld_stats and fld_seq.
//
// Usage: i_in carries items (req_type 0 launch trigger, 1 altitude sample);
// o_out returns exactly one result item per input item, in order, with the
// flight mode, a landing flag and reason, and the sample count of the flight.
// i_cfg_we with i_cfg_wdata writes init_failed; write it only while idle.
// Path: an accepted item passes its queue entry, the four registers of the test
// pipeline and the result register. Throughput: one item per cycle while the
// receiver does not stall; the mode and count update of the sequencer and the
// running window sums each keep pace, and the four-stage test pipeline runs ahead of them.
// Reset: mode pre-launch, count zero, queue and pipeline empty. The window store
// holds no reset value and needs no clearing pass; a test reads only samples of
// the current flight.
// Receiver stall: the result register and pipeline hold, the four-entry input
// queue keeps taking items until full, then i_in.ready drops.
`timescale 1ns / 1ps
`default_nettype none
module flight_landing_detector #(
    parameter int LOG_DEPTH  = 2048,
    parameter int WINDOW_LEN = 5
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fld_in_if.sink    i_in,
    fld_out_if.source o_out,
    input  logic      i_cfg_we,
    input  logic      i_cfg_wdata
);
    import fld_pkg::*;

    logic     en;
    logic     q_valid;
    t_item    q_item;
    logic     v_valid;
    t_verdict verdict;

    fld_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_pop   (en),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    fld_stats #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_stats (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (q_valid),
        .i_item    (q_item),
        .o_valid   (v_valid),
        .o_verdict (verdict)
    );

    fld_seq #(
        .LOG_DEPTH  (LOG_DEPTH),
        .WINDOW_LEN (WINDOW_LEN)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (v_valid),
        .i_verdict   (verdict),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_en        (en),
        .o_out       (o_out)
    );

endmodule
`default_nettype wire

@@ src/fld_checker.sv @@
// Port-level checker of the flight landing detector, bound to the top level.
// Depends on fld_pkg and flight_landing_detector_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "flight_landing_detector_assert.svh"
module fld_checker #(
    parameter int LOG_DEPTH = 2048
) (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_valid,
    input logic                      i_ready,
    input logic [1:0]                i_mode,
    input logic                      i_landed_now,
    input logic [1:0]                i_land_reason,
    input logic [fld_pkg::IDX_W-1:0] i_sample_index
);
    import fld_pkg::*;

    // A landing item always reports landed mode and a real reason.
    `FLD_ASSERT_IMP(a_land_mode, i_clk, i_rst_n, i_valid && i_landed_now, i_mode == MODE_LAND && (i_land_reason == REASON_DEV || i_land_reason == REASON_FULL), "landing item without landed mode or reason")
    `FLD_ASSERT_IMP(a_no_reason, i_clk, i_rst_n, i_valid && !i_landed_now, i_land_reason == REASON_NONE, "reason set on an item that did not land")
    // A full store ends the flight exactly at the store depth.
    `FLD_ASSERT_IMP(a_full_index, i_clk, i_rst_n, i_valid && i_landed_now && i_land_reason == REASON_FULL, i_sample_index == IDX_W'(LOG_DEPTH), "buffer-full landing at wrong count")
    // Pre-launch is entered only with an empty count.
    `FLD_ASSERT_IMP(a_pre_empty, i_clk, i_rst_n, i_valid && i_mode == MODE_PRE, i_sample_index == '0, "samples counted in pre-launch mode")
    `FLD_ASSERT_NEXT(a_hold, i_clk, i_rst_n, i_valid && !i_ready, i_valid && $stable({i_mode, i_landed_now, i_land_reason, i_sample_index}), "stalled result item changed")

endmodule

bind flight_landing_detector fld_checker #(
    .LOG_DEPTH (LOG_DEPTH)
) u_fld_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (o_out.valid),
    .i_ready        (o_out.ready),
    .i_mode         (o_out.mode),
    .i_landed_now   (o_out.landed_now),
    .i_land_reason  (o_out.land_reason),
    .i_sample_index (o_out.sample_index)
);
`default_nettype wire
